// File: sv/thfe_pkg.sv
// Shared types, constants and CRC function for the humidity and temperature frame encoder.
`timescale 1ns / 1ps

package thfe_pkg;

    // register indexes on the configuration port
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] REG_TEMP  = 1'b0;
    localparam logic [0:0] REG_HUM   = 1'b1;

    localparam logic signed [15:0] TEMP_RESET = 16'sd2500;
    localparam logic signed [15:0] HUM_RESET  = 16'sd5000;

    // clamping, in hundredths
    localparam int TEMP_OFFSET = 4500;
    localparam int TEMP_SPAN   = 17500;
    localparam int HUM_MAX     = 10000;
    localparam int TEMP_OFF_W  = 15;
    localparam int HUM_W       = 14;

    // code = floor(x * 65535 / span) = floor(floor(x * 13107 >> pre) / div)
    localparam int SCALE_MUL = 13107;

    localparam int          TEMP_PRE_SHIFT   = 2;
    localparam int          TEMP_N_W         = 26;
    localparam int          TEMP_DIV         = 875;
    localparam int unsigned TEMP_RECIP       = 32'd78536544;
    localparam int          TEMP_RECIP_SHIFT = 36;

    localparam int          HUM_PRE_SHIFT   = 4;
    localparam int          HUM_N_W         = 23;
    localparam int          HUM_DIV         = 125;
    localparam int unsigned HUM_RECIP       = 32'd68719476;
    localparam int          HUM_RECIP_SHIFT = 33;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // load enables for the stages held inside the scaler
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    // one byte of CRC-8, MSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] c_in, input logic [7:0] d);
        logic [7:0] c;
        c = c_in ^ d;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: sv/thfe_scale.sv
// Constant-coefficient scaler: three stages from a clamped value to a 16-bit raw code.
`timescale 1ns / 1ps

module thfe_scale #(
    parameter int          IN_W        = 15,
    parameter int          PRE_SHIFT   = 2,
    parameter int          N_W         = 26,
    parameter int          DIV         = 875,
    parameter int unsigned RECIP       = 32'd78536544,
    parameter int          RECIP_SHIFT = 36
) (
    input  logic                clk,
    input  thfe_pkg::adv_t      adv,
    input  logic [IN_W-1:0]     val,
    output logic [15:0]         code
);

    localparam int P_W     = IN_W + 14;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int DIV_W   = $clog2(DIV + 1);
    localparam int Q_W     = 17;
    localparam int QD_W    = Q_W + DIV_W;

    logic [P_W-1:0]         prod1;
    logic [N_W-1:0]         n_reg, n_next;
    logic [N_W+RECIP_W-1:0] prod2;
    logic [Q_W-1:0]         qe_reg, qe_next;
    logic [N_W-1:0]         n3_reg;
    logic [QD_W-1:0]        qd;
    logic [N_W-1:0]         rem;
    logic [15:0]            code_reg, code_next;

    // stage 2: x * 13107, pre-shift
    assign prod1  = P_W'(val) * P_W'(thfe_pkg::SCALE_MUL);
    assign n_next = N_W'(prod1 >> PRE_SHIFT);

    // stage 3: reciprocal estimate, at most one low
    assign prod2   = (N_W+RECIP_W)'(n_reg) * (N_W+RECIP_W)'(RECIP);
    assign qe_next = Q_W'(prod2 >> RECIP_SHIFT);

    // stage 4: remainder correction
    assign qd        = QD_W'(qe_reg) * QD_W'(DIV);
    assign rem       = n3_reg - N_W'(qd);
    assign code_next = 16'(qe_reg) + 16'(rem >= N_W'(DIV));

    always_ff @(posedge clk)
    begin
        if (adv.s2)
            n_reg <= n_next;
        if (adv.s3)
        begin
            qe_reg <= qe_next;
            n3_reg <= n_reg;
        end
        if (adv.s4)
            code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

// File: sv/temp_humidity_frame_encoder_unit.sv
// Top level of the humidity and temperature frame encoder.
// An accepted request passes the clamp register, the three scaler stages, the CRC stage and the output register.
// Throughput: one transaction per cycle while m_tready holds no stage; six registered stages with per-stage stall.
// Stage depth is set by the two reciprocal multiplies and the two CRC byte steps.
// Reset (rst_n low, asynchronous) empties the pipeline and loads 25.00 C and 50.00 %.
`timescale 1ns / 1ps

module temp_humidity_frame_encoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [thfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [0] read_request
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] temp_high_byte, [15:8] temp_low_byte, [23:16] temp_check_byte,
    // [31:24] hum_high_byte, [39:32] hum_low_byte, [47:40] hum_check_byte
    output logic [47:0]                    m_tdata
);

    logic signed [15:0] temp_reg, hum_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_vld_reg;
    logic en1, en2, en3, en4, en5, en_out;
    logic accept;

    logic signed [16:0]              t_sum;
    logic [thfe_pkg::TEMP_OFF_W-1:0] t_off_next, t_off_reg;
    logic [thfe_pkg::HUM_W-1:0]      h_next, h_reg;

    thfe_pkg::adv_t adv;
    logic [15:0]    t_code, h_code;
    logic [15:0]    t_code5_reg, h_code5_reg;
    logic [7:0]     t_c1_reg, h_c1_reg;
    logic [47:0]    frame_next, frame_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= thfe_pkg::TEMP_RESET;
            hum_reg  <= thfe_pkg::HUM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                thfe_pkg::REG_TEMP: temp_reg <= cfg_data;
                thfe_pkg::REG_HUM:  hum_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage advance, bubbles squeeze out
    assign en_out   = !out_vld_reg || m_tready;
    assign en5      = !v5_reg || en_out;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    assign adv.s2 = en2;
    assign adv.s3 = en3;
    assign adv.s4 = en4;

    // saturation
    assign t_sum = 17'(temp_reg) + 17'(thfe_pkg::TEMP_OFFSET);

    always_comb
    begin
        if (t_sum < 0)
            t_off_next = '0;
        else if (t_sum > thfe_pkg::TEMP_SPAN)
            t_off_next = thfe_pkg::TEMP_OFF_W'(thfe_pkg::TEMP_SPAN);
        else
            t_off_next = thfe_pkg::TEMP_OFF_W'(t_sum);

        if (hum_reg < 0)
            h_next = '0;
        else if (hum_reg > thfe_pkg::HUM_MAX)
            h_next = thfe_pkg::HUM_W'(thfe_pkg::HUM_MAX);
        else
            h_next = thfe_pkg::HUM_W'(hum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept && s_tdata[0];
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
            if (en_out)
                out_vld_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            t_off_reg <= t_off_next;
            h_reg     <= h_next;
        end
    end

    thfe_scale #(
        .IN_W        (thfe_pkg::TEMP_OFF_W),
        .PRE_SHIFT   (thfe_pkg::TEMP_PRE_SHIFT),
        .N_W         (thfe_pkg::TEMP_N_W),
        .DIV         (thfe_pkg::TEMP_DIV),
        .RECIP       (thfe_pkg::TEMP_RECIP),
        .RECIP_SHIFT (thfe_pkg::TEMP_RECIP_SHIFT)
    ) u_temp_scale (
        .clk  (clk),
        .adv  (adv),
        .val  (t_off_reg),
        .code (t_code)
    );

    thfe_scale #(
        .IN_W        (thfe_pkg::HUM_W),
        .PRE_SHIFT   (thfe_pkg::HUM_PRE_SHIFT),
        .N_W         (thfe_pkg::HUM_N_W),
        .DIV         (thfe_pkg::HUM_DIV),
        .RECIP       (thfe_pkg::HUM_RECIP),
        .RECIP_SHIFT (thfe_pkg::HUM_RECIP_SHIFT)
    ) u_hum_scale (
        .clk  (clk),
        .adv  (adv),
        .val  (h_reg),
        .code (h_code)
    );

    // CRC over high byte, then low byte in the output stage
    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            t_code5_reg <= t_code;
            h_code5_reg <= h_code;
            t_c1_reg    <= thfe_pkg::crc_byte(thfe_pkg::CRC_INIT, t_code[15:8]);
            h_c1_reg    <= thfe_pkg::crc_byte(thfe_pkg::CRC_INIT, h_code[15:8]);
        end
        if (en_out)
            frame_reg <= frame_next;
    end

    assign frame_next = {thfe_pkg::crc_byte(h_c1_reg, h_code5_reg[7:0]),
                         h_code5_reg[7:0], h_code5_reg[15:8],
                         thfe_pkg::crc_byte(t_c1_reg, t_code5_reg[7:0]),
                         t_code5_reg[7:0], t_code5_reg[15:8]};

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = frame_reg;

endmodule

// File: sv/thfe_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
`timescale 1ns / 1ps

module thfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // output stalled: transaction stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // an empty output stage means the whole pipeline can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    a_temp_crc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:16] == thfe_pkg::crc_byte(
            thfe_pkg::crc_byte(thfe_pkg::CRC_INIT, m_tdata[7:0]), m_tdata[15:8]))
        else $error("temperature CRC mismatch");

    a_hum_crc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:40] == thfe_pkg::crc_byte(
            thfe_pkg::crc_byte(thfe_pkg::CRC_INIT, m_tdata[31:24]), m_tdata[39:32]))
        else $error("humidity CRC mismatch");

endmodule

bind temp_humidity_frame_encoder_unit thfe_checker u_thfe_checker (.*);

// File: tb/thfe_frame_checker.sv
// Frame checker: predicts each measurement frame from observed writes and requests, and compares.
`timescale 1ns / 1ps

module thfe_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [thfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [47:0]                    m_tdata,
    output int                             error_count,
    output int                             frames_pending,
    output int                             frames_checked
);

    typedef struct packed {
        logic [7:0] temp_hi;
        logic [7:0] temp_lo;
        logic [7:0] temp_crc;
        logic [7:0] hum_hi;
        logic [7:0] hum_lo;
        logic [7:0] hum_crc;
    } frame_t;

    logic signed [15:0] temp_setting;
    logic signed [15:0] hum_setting;
    frame_t             expected_frames[$];
    frame_t             want;

    function automatic logic [7:0] crc8_word(input logic [15:0] word);
        logic [7:0] c;
        logic       fb;
        c = 8'hFF;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ word[i];
            c  = {c[6:0], 1'b0};
            if (fb)
                c = c ^ 8'h31;
        end
        return c;
    endfunction

    function automatic frame_t predict_frame(input logic signed [15:0] t_set,
                                             input logic signed [15:0] h_set);
        int         t;
        int         h;
        logic [15:0] t_code;
        logic [15:0] h_code;
        frame_t     f;
        t = t_set;
        h = h_set;
        if (t < -thfe_pkg::TEMP_OFFSET)
            t = -thfe_pkg::TEMP_OFFSET;
        if (t > thfe_pkg::TEMP_SPAN - thfe_pkg::TEMP_OFFSET)
            t = thfe_pkg::TEMP_SPAN - thfe_pkg::TEMP_OFFSET;
        if (h < 0)
            h = 0;
        if (h > thfe_pkg::HUM_MAX)
            h = thfe_pkg::HUM_MAX;
        t_code     = 16'((t + thfe_pkg::TEMP_OFFSET) * 65535 / thfe_pkg::TEMP_SPAN);
        h_code     = 16'(h * 65535 / thfe_pkg::HUM_MAX);
        f.temp_hi  = t_code[15:8];
        f.temp_lo  = t_code[7:0];
        f.temp_crc = crc8_word(t_code);
        f.hum_hi   = h_code[15:8];
        f.hum_lo   = h_code[7:0];
        f.hum_crc  = crc8_word(h_code);
        return f;
    endfunction

    task automatic check_byte(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %02h, actual %02h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_setting = thfe_pkg::TEMP_RESET;
            hum_setting  = thfe_pkg::HUM_RESET;
            expected_frames.delete();
            error_count    = 0;
            frames_pending = 0;
            frames_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("frame transaction with no request outstanding: %012h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_byte("temp_high_byte",  want.temp_hi,  m_tdata[7:0]);
                    check_byte("temp_low_byte",   want.temp_lo,  m_tdata[15:8]);
                    check_byte("temp_check_byte", want.temp_crc, m_tdata[23:16]);
                    check_byte("hum_high_byte",   want.hum_hi,   m_tdata[31:24]);
                    check_byte("hum_low_byte",    want.hum_lo,   m_tdata[39:32]);
                    check_byte("hum_check_byte",  want.hum_crc,  m_tdata[47:40]);
                    frames_checked++;
                end
            end
            if (s_tvalid && s_tready && s_tdata[0])
                expected_frames.push_back(predict_frame(temp_setting, hum_setting));
            if (cfg_we)
            begin
                case (cfg_index)
                    thfe_pkg::REG_TEMP: temp_setting = cfg_data;
                    thfe_pkg::REG_HUM:  hum_setting  = cfg_data;
                    default:  ;
                endcase
            end
            frames_pending = expected_frames.size();
        end
    end

endmodule

// File: tb/tb_temp_humidity_frame_encoder_unit.sv
// Testbench top: drives requests and register writes into the frame encoder and reports the verdict.
`timescale 1ns / 1ps

module tb_temp_humidity_frame_encoder_unit;

    localparam int REQUEST_TARGET = 1250;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 10;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [thfe_pkg::CFG_IDX_W-1:0] cfg_index = thfe_pkg::REG_TEMP;
    logic [15:0]                    cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [47:0]                    m_tdata;

    int error_count;
    int frames_pending;
    int frames_checked;

    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;
    bit rx_hold = 1'b0;

    int requests_sent = 0;
    int ignored_sent  = 0;
    int cfg_writes    = 0;

    int temp_edges [7] = '{-10000, -4501, -4500, 0, 13000, 13001, 20000};
    int hum_edges  [6] = '{-10000, -1, 0, 10000, 10001, 20000};

    temp_humidity_frame_encoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] read_request
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // temp hi, lo, crc, hum hi, lo, crc from bit 0 up
    );

    thfe_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .error_count    (error_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[temp_humidity_frame_encoder_unit] ERROR");
        $finish;
    end

    // frame receiver: per-transaction back-pressure, plus a long hold-off on request
    initial
    begin
        int k;
        forever
        begin
            if (rx_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            k = rx_fast ? 0 : $urandom_range(0, 12);
            if (k > 0)
            begin
                m_tready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && !rx_hold)
                @(posedge clk);
        end
    end

    task automatic send_item(input bit req);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req)
            requests_sent++;
        else
            ignored_sent++;
        gap = tx_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pause_and_drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_conditions(input int t_val, input int h_val);
        pause_and_drain();
        cfg_we    <= 1'b1;
        cfg_index <= thfe_pkg::REG_TEMP;
        cfg_data  <= 16'(t_val);
        @(posedge clk);
        cfg_index <= thfe_pkg::REG_HUM;
        cfg_data  <= 16'(h_val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        cfg_writes += 2;
    endtask

    initial
    begin
        int phase;
        int n;
        int t_val;
        int h_val;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values, an ignored transaction, then each clamp boundary
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        for (int i = 0; i < 7; i++)
        begin
            set_conditions(temp_edges[i], hum_edges[i % 6]);
            send_item(1'b1);
        end
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        repeat (4) send_item(1'b1);
        send_item(1'b0);

        phase = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            phase++;
            if ($urandom_range(0, 2) == 0)
            begin
                t_val = ($urandom_range(0, 3) == 0) ? temp_edges[$urandom_range(0, 6)]
                                                    : int'($urandom_range(0, 30000)) - 10000;
                h_val = ($urandom_range(0, 3) == 0) ? hum_edges[$urandom_range(0, 5)]
                                                    : int'($urandom_range(0, 30000)) - 10000;
                set_conditions(t_val, h_val);
            end
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if (phase == 8 || phase == 25)
            begin
                // receiver stalls while requests keep coming, then sender waits it out
                tx_fast = 1'b1;
                rx_hold = 1'b1;
                repeat (40) send_item(1'b1);
                pause_and_drain();
            end
            n = $urandom_range(10, 60);
            repeat (n) send_item($urandom_range(0, 6) != 0);
        end

        pause_and_drain();
        repeat (20) @(posedge clk);
        if (frames_pending != 0)
            $error("%0d expected frames never arrived", frames_pending);
        $display("Covered %0d frame requests, %0d ignored transactions, %0d register writes;",
                 requests_sent, ignored_sent, cfg_writes);
        $display("%0d frames compared, with clamp boundaries and long receiver stalls.",
                 frames_checked);
        if (error_count == 0 && frames_pending == 0)
            $display("[temp_humidity_frame_encoder_unit] OK");
        else
            $display("[temp_humidity_frame_encoder_unit] ERROR");
        $finish;
    end

endmodule
